@@ src/sdspi_pkg.sv @@
// shared constants, codes and word types of the sd card spi host
`timescale 1ns / 1ps
`default_nettype none
package sdspi_pkg;

  // block geometry and polling limits
  localparam int BLOCK_BYTES    = 512;
  localparam int RESPONSE_POLLS = 128;
  localparam int START_POLLS    = 255;
  localparam int WAKE_BYTES     = 12;
  localparam int ATTEMPT_MAX    = 255;

  // byte counter must hold the block length itself
  localparam int BC_W = $clog2(BLOCK_BYTES + 1);

  // input command codes
  localparam logic [1:0] CMD_BYTE = 2'd0;
  localparam logic [1:0] CMD_INIT = 2'd1;
  localparam logic [1:0] CMD_READ = 2'd2;

  // status codes
  localparam logic [2:0] ST_BUSY       = 3'd0;
  localparam logic [2:0] ST_OK         = 3'd1;
  localparam logic [2:0] ST_RESET_TO   = 3'd2;
  localparam logic [2:0] ST_OPCOND_TO  = 3'd3;
  localparam logic [2:0] ST_CMD_ERR    = 3'd4;
  localparam logic [2:0] ST_NO_TOKEN   = 3'd5;

  // configuration register indexes
  localparam logic CFG_RETRY_LIMIT = 1'b0;
  localparam logic CFG_GAP_BYTES   = 1'b1;

  // bytes on the wire
  localparam logic [7:0] IDLE_BYTE   = 8'hFF;
  localparam logic [7:0] START_TOKEN = 8'hFE;
  localparam logic [7:0] CMD0_CRC    = 8'h95;
  localparam logic [7:0] OP_CMD0     = 8'h40;
  localparam logic [7:0] OP_CMD1     = 8'h41;
  localparam logic [7:0] OP_READ     = 8'h51;
  localparam logic [7:0] R1_IDLE     = 8'h01;

  // one input word
  typedef struct packed {
    logic [1:0]  command;
    logic [22:0] block_address;
    logic [7:0]  received_byte;
  } in_word_t;

  // one result word
  typedef struct packed {
    logic       exchange;
    logic [7:0] send_byte;
    logic       chip_select;
    logic       fast_clock;
    logic       data_valid;
    logic [7:0] data_byte;
    logic       last_data;
    logic       done_res;
    logic [2:0] status;
  } res_t;

endpackage
`default_nettype wire

@@ src/sdspi_in_if.sv @@
// input channel: command word with valid/ready handshake
`timescale 1ns / 1ps
`default_nettype none
interface sdspi_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  command;
  logic [22:0] block_address;
  logic [7:0]  received_byte;

  modport source (output valid, command, block_address, received_byte, input ready);
  modport sink   (input valid, command, block_address, received_byte, output ready);
endinterface
`default_nettype wire

@@ src/sdspi_out_if.sv @@
// result channel: exchange request, payload byte and status with valid/ready
`timescale 1ns / 1ps
`default_nettype none
interface sdspi_out_if;
  logic       valid;
  logic       ready;
  logic       exchange;
  logic [7:0] send_byte;
  logic       chip_select;
  logic       fast_clock;
  logic       data_valid;
  logic [7:0] data_byte;
  logic       last_data;
  logic       done_res;
  logic [2:0] status;

  modport source (output valid, exchange, send_byte, chip_select, fast_clock, data_valid,
                  data_byte, last_data, done_res, status, input ready);
  modport sink   (input valid, exchange, send_byte, chip_select, fast_clock, data_valid,
                  data_byte, last_data, done_res, status, output ready);
endinterface
`default_nettype wire

@@ src/sdspi_engine.sv @@
// protocol sequencer: per-word state update and registered result word
`timescale 1ns / 1ps
`default_nettype none
module sdspi_engine (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               step,
  input  wire sdspi_pkg::in_word_t word,
  input  wire logic [7:0]         retry_limit,
  input  wire logic [7:0]         gap_bytes,
  input  wire logic               out_ready,
  output logic                    out_valid,
  output sdspi_pkg::res_t         res
);

  typedef enum logic [3:0] {
    PH_IDLE, PH_WAKE, PH_DUMMY, PH_FRAME, PH_POLL, PH_TRAIL0_OK, PH_TRAIL0_RETRY,
    PH_GAP, PH_TRAIL1, PH_START, PH_DATA, PH_CRC
  } phase_t;

  phase_t                     phase_r, phase_nxt;
  logic [7:0]                 frame_r [6];
  logic [7:0]                 frame_nxt [6];
  logic [sdspi_pkg::BC_W-1:0] byte_count_r, byte_count_nxt;
  logic [8:0]                 attempt_r, attempt_nxt;
  logic [7:0]                 poll_r, poll_nxt;
  logic [7:0]                 gap_r, gap_nxt;
  logic                       fast_r, fast_nxt;
  logic                       out_valid_r, out_valid_nxt;
  sdspi_pkg::res_t            res_r, res_nxt;
  logic [2:0]                 frame_idx;
  logic [7:0]                 rx;

  assign rx        = word.received_byte;
  assign frame_idx = byte_count_r[2:0] + 3'd1;

  // next state and result for one word
  always_comb begin
    phase_nxt      = phase_r;
    frame_nxt      = frame_r;
    byte_count_nxt = byte_count_r;
    attempt_nxt    = attempt_r;
    poll_nxt       = poll_r;
    gap_nxt        = gap_r;
    fast_nxt       = fast_r;
    res_nxt        = '0;
    res_nxt.send_byte = sdspi_pkg::IDLE_BYTE;

    if (word.command == sdspi_pkg::CMD_INIT) begin
      fast_nxt       = 1'b0;
      phase_nxt      = PH_WAKE;
      byte_count_nxt = sdspi_pkg::BC_W'(1);
      res_nxt.exchange = 1'b1;
    end else if (word.command == sdspi_pkg::CMD_READ) begin
      fast_nxt     = 1'b1;
      frame_nxt[0] = sdspi_pkg::OP_READ;
      frame_nxt[1] = word.block_address[22:15];
      frame_nxt[2] = word.block_address[14:7];
      frame_nxt[3] = {word.block_address[6:0], 1'b0};
      frame_nxt[4] = 8'h00;
      phase_nxt    = PH_DUMMY;
      res_nxt.exchange = 1'b1;
    end else begin
      unique case (phase_r)
        // wake bytes, then first reset command
        PH_WAKE: begin
          if (byte_count_r < sdspi_pkg::BC_W'(sdspi_pkg::WAKE_BYTES)) begin
            byte_count_nxt   = byte_count_r + 1'b1;
            res_nxt.exchange = 1'b1;
          end else begin
            attempt_nxt = '0;
            if (retry_limit == 8'd0) begin
              phase_nxt        = PH_IDLE;
              res_nxt.done_res = 1'b1;
              res_nxt.status   = sdspi_pkg::ST_RESET_TO;
            end else begin
              frame_nxt[0] = sdspi_pkg::OP_CMD0;
              frame_nxt[1] = 8'h00;
              frame_nxt[2] = 8'h00;
              frame_nxt[3] = 8'h00;
              frame_nxt[4] = 8'h00;
              frame_nxt[5] = sdspi_pkg::CMD0_CRC;
              phase_nxt    = PH_DUMMY;
              res_nxt.exchange = 1'b1;
            end
          end
        end
        // first command frame byte, card selected
        PH_DUMMY: begin
          phase_nxt           = PH_FRAME;
          byte_count_nxt      = '0;
          res_nxt.exchange    = 1'b1;
          res_nxt.send_byte   = frame_r[0];
          res_nxt.chip_select = 1'b1;
        end
        // command frame bytes
        PH_FRAME: begin
          res_nxt.exchange    = 1'b1;
          res_nxt.chip_select = 1'b1;
          if (byte_count_r < sdspi_pkg::BC_W'(5)) begin
            byte_count_nxt    = byte_count_r + 1'b1;
            res_nxt.send_byte = frame_r[frame_idx];
          end else begin
            phase_nxt = PH_POLL;
            poll_nxt  = 8'd1;
          end
        end
        // response poll and dispatch by command
        PH_POLL: begin
          if (!rx[7] || poll_r >= 8'(sdspi_pkg::RESPONSE_POLLS)) begin
            if (frame_r[0] == sdspi_pkg::OP_CMD0) begin
              attempt_nxt      = attempt_r + 1'b1;
              phase_nxt        = (rx == sdspi_pkg::R1_IDLE) ? PH_TRAIL0_OK : PH_TRAIL0_RETRY;
              res_nxt.exchange = 1'b1;
            end else if (frame_r[0] == sdspi_pkg::OP_CMD1) begin
              if (rx == 8'h00 || attempt_r >= 9'(sdspi_pkg::ATTEMPT_MAX)) begin
                phase_nxt        = PH_IDLE;
                res_nxt.done_res = 1'b1;
                res_nxt.status   = (rx == 8'h00 && attempt_r < 9'(sdspi_pkg::ATTEMPT_MAX)) ?
                                   sdspi_pkg::ST_OK : sdspi_pkg::ST_OPCOND_TO;
              end else begin
                attempt_nxt = attempt_r + 1'b1;
                if (gap_bytes != 8'd0) begin
                  phase_nxt = PH_GAP;
                  gap_nxt   = 8'd1;
                end else begin
                  phase_nxt = PH_TRAIL1;
                end
                res_nxt.exchange = 1'b1;
              end
            end else begin
              if (rx != 8'h00) begin
                phase_nxt        = PH_IDLE;
                res_nxt.done_res = 1'b1;
                res_nxt.status   = sdspi_pkg::ST_CMD_ERR;
              end else begin
                phase_nxt           = PH_START;
                poll_nxt            = 8'd1;
                res_nxt.exchange    = 1'b1;
                res_nxt.chip_select = 1'b1;
              end
            end
          end else begin
            poll_nxt            = poll_r + 1'b1;
            res_nxt.exchange    = 1'b1;
            res_nxt.chip_select = 1'b1;
          end
        end
        // card reported idle state: move on to op cond
        PH_TRAIL0_OK: begin
          frame_nxt[0]     = sdspi_pkg::OP_CMD1;
          attempt_nxt      = '0;
          phase_nxt        = PH_DUMMY;
          res_nxt.exchange = 1'b1;
        end
        PH_TRAIL0_RETRY: begin
          if (attempt_r >= {1'b0, retry_limit}) begin
            phase_nxt        = PH_IDLE;
            res_nxt.done_res = 1'b1;
            res_nxt.status   = sdspi_pkg::ST_RESET_TO;
          end else begin
            phase_nxt        = PH_DUMMY;
            res_nxt.exchange = 1'b1;
          end
        end
        // idle gap between op cond attempts
        PH_GAP: begin
          if (gap_r < gap_bytes) begin
            gap_nxt = gap_r + 1'b1;
          end else begin
            phase_nxt = PH_TRAIL1;
          end
          res_nxt.exchange = 1'b1;
        end
        PH_TRAIL1: begin
          phase_nxt        = PH_DUMMY;
          res_nxt.exchange = 1'b1;
        end
        // wait for start token
        PH_START: begin
          if (rx == sdspi_pkg::START_TOKEN) begin
            phase_nxt           = PH_DATA;
            byte_count_nxt      = sdspi_pkg::BC_W'(1);
            res_nxt.exchange    = 1'b1;
            res_nxt.chip_select = 1'b1;
          end else if (poll_r >= 8'(sdspi_pkg::START_POLLS)) begin
            phase_nxt        = PH_IDLE;
            res_nxt.done_res = 1'b1;
            res_nxt.status   = sdspi_pkg::ST_NO_TOKEN;
          end else begin
            poll_nxt            = poll_r + 1'b1;
            res_nxt.exchange    = 1'b1;
            res_nxt.chip_select = 1'b1;
          end
        end
        // payload stream
        PH_DATA: begin
          res_nxt.data_valid  = 1'b1;
          res_nxt.data_byte   = rx;
          res_nxt.exchange    = 1'b1;
          res_nxt.chip_select = 1'b1;
          if (byte_count_r >= sdspi_pkg::BC_W'(sdspi_pkg::BLOCK_BYTES)) begin
            res_nxt.last_data = 1'b1;
            phase_nxt         = PH_CRC;
            byte_count_nxt    = sdspi_pkg::BC_W'(1);
          end else begin
            byte_count_nxt = byte_count_r + 1'b1;
          end
        end
        // crc bytes are clocked out and dropped
        PH_CRC: begin
          if (byte_count_r < sdspi_pkg::BC_W'(2)) begin
            byte_count_nxt      = byte_count_r + 1'b1;
            res_nxt.exchange    = 1'b1;
            res_nxt.chip_select = 1'b1;
          end else begin
            phase_nxt        = PH_IDLE;
            res_nxt.done_res = 1'b1;
            res_nxt.status   = sdspi_pkg::ST_OK;
          end
        end
        default: begin
          phase_nxt = PH_IDLE;
        end
      endcase
    end
    res_nxt.fast_clock = fast_nxt;
  end

  // result slot: filled on a step, emptied when taken
  always_comb begin
    if (step) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  // state and result registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_IDLE;
      frame_r      <= '{default: 8'h00};
      byte_count_r <= '0;
      attempt_r    <= '0;
      poll_r       <= '0;
      gap_r        <= '0;
      fast_r       <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (step) begin
        phase_r      <= phase_nxt;
        frame_r      <= frame_nxt;
        byte_count_r <= byte_count_nxt;
        attempt_r    <= attempt_nxt;
        poll_r       <= poll_nxt;
        gap_r        <= gap_nxt;
        fast_r       <= fast_nxt;
      end
    end
    if (step) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign res       = res_r;

endmodule
`default_nettype wire

@@ src/sd_spi_init_and_block_read_top.sv @@
// sd card spi host top: config registers, input word register and sequencer
// path: an accepted word is held in the input register, then its result is registered in the result register
// throughput: one word per cycle; input register and result register both stay full
//   while the result side is ready, set by the single state update per word
// reset: synchronous active-low rst_n empties both registers, puts the sequencer in
//   idle at slow clock and loads retry limit 10 and gap bytes 32
`timescale 1ns / 1ps
`default_nettype none
module sd_spi_init_and_block_read_top (
  input  wire logic       clk,
  input  wire logic       rst_n,
  sdspi_in_if.sink        in_ch,
  sdspi_out_if.source     out_ch,
  input  wire logic       cfg_we,
  input  wire logic       cfg_index,
  input  wire logic [7:0] cfg_wdata
);

  logic [7:0]           retry_lim_r, retry_lim_nxt;
  logic [7:0]           gap_bytes_r, gap_bytes_nxt;
  logic                 in_valid_r, in_valid_nxt;
  sdspi_pkg::in_word_t  in_word_r;
  logic                 in_fire;
  logic                 step;
  logic                 eng_valid;
  sdspi_pkg::res_t      eng_res;

  // input register moves on whenever the result slot is free or draining
  assign step        = in_valid_r && (!eng_valid || out_ch.ready);
  assign in_ch.ready = !in_valid_r || step;
  assign in_fire     = in_ch.valid && in_ch.ready;

  always_comb begin
    if (in_fire) begin
      in_valid_nxt = 1'b1;
    end else if (step) begin
      in_valid_nxt = 1'b0;
    end else begin
      in_valid_nxt = in_valid_r;
    end
  end

  // configuration write decode
  always_comb begin
    retry_lim_nxt = retry_lim_r;
    gap_bytes_nxt = gap_bytes_r;
    if (cfg_we) begin
      unique case (cfg_index)
        sdspi_pkg::CFG_RETRY_LIMIT: retry_lim_nxt = cfg_wdata;
        sdspi_pkg::CFG_GAP_BYTES:   gap_bytes_nxt = cfg_wdata;
        default:                    retry_lim_nxt = retry_lim_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      retry_lim_r <= 8'd10;
      gap_bytes_r <= 8'd32;
      in_valid_r  <= 1'b0;
    end else begin
      retry_lim_r <= retry_lim_nxt;
      gap_bytes_r <= gap_bytes_nxt;
      in_valid_r  <= in_valid_nxt;
    end
    if (in_fire) begin
      in_word_r.command       <= in_ch.command;
      in_word_r.block_address <= in_ch.block_address;
      in_word_r.received_byte <= in_ch.received_byte;
    end
  end

  // sequencer with result register
  sdspi_engine u_engine (
    .clk         (clk),
    .rst_n       (rst_n),
    .step        (step),
    .word        (in_word_r),
    .retry_limit (retry_lim_r),
    .gap_bytes   (gap_bytes_r),
    .out_ready   (out_ch.ready),
    .out_valid   (eng_valid),
    .res         (eng_res)
  );

  // result channel
  assign out_ch.valid       = eng_valid;
  assign out_ch.exchange    = eng_res.exchange;
  assign out_ch.send_byte   = eng_res.send_byte;
  assign out_ch.chip_select = eng_res.chip_select;
  assign out_ch.fast_clock  = eng_res.fast_clock;
  assign out_ch.data_valid  = eng_res.data_valid;
  assign out_ch.data_byte   = eng_res.data_byte;
  assign out_ch.last_data   = eng_res.last_data;
  assign out_ch.done_res    = eng_res.done_res;
  assign out_ch.status      = eng_res.status;

endmodule
`default_nettype wire

@@ src/sdspi_checker.sv @@
// port-level checks on the result channel of the sd card spi host
`timescale 1ns / 1ps
`default_nettype none
module sdspi_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic       exchange,
  input wire logic [7:0] send_byte,
  input wire logic       chip_select,
  input wire logic       data_valid,
  input wire logic [7:0] data_byte,
  input wire logic       last_data,
  input wire logic       done_res,
  input wire logic [2:0] status
);

  // a stalled result word holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(send_byte) && $stable(status)
      && $stable(data_byte))
    else $error("result word changed while stalled");

  // no exchange means idle byte with card deselected
  a_idle_byte: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !exchange |-> send_byte == sdspi_pkg::IDLE_BYTE && !chip_select)
    else $error("idle result drives card");

  // status only reported with done
  a_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !done_res |-> status == sdspi_pkg::ST_BUSY)
    else $error("status without done");

  // payload fields clear outside the data stream
  a_payload: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !data_valid |-> data_byte == 8'h00 && !last_data)
    else $error("payload fields set without data");

endmodule

bind sd_spi_init_and_block_read_top sdspi_checker u_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .exchange    (out_ch.exchange),
  .send_byte   (out_ch.send_byte),
  .chip_select (out_ch.chip_select),
  .data_valid  (out_ch.data_valid),
  .data_byte   (out_ch.data_byte),
  .last_data   (out_ch.last_data),
  .done_res    (out_ch.done_res),
  .status      (out_ch.status)
);
`default_nettype wire
